// ===== sv/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

   localparam int DEPTH   = 256;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int RSP_W   = 1 + COUNT_W + 2 * DATA_W;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_NONE      = 3'd0,
      OP_PUSH_HEAD = 3'd1,
      OP_PUSH_TAIL = 3'd2,
      OP_POP_HEAD  = 3'd3,
      OP_POP_TAIL  = 3'd4,
      OP_CLEAR     = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } wr_port_type;

endpackage

`default_nettype wire

// ===== sv/deq_store.sv =====
`default_nettype none

module deq_store (
   input  wire logic                        clock,
   input  wire deq_pkg::wr_port_type        wr,
   input  wire logic [deq_pkg::ADDR_W-1:0]  rd_addr,
   output logic      [deq_pkg::DATA_W-1:0]  rd_data
);
   import deq_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_top.sv =====
// Bounded double-ended queue of 32-bit words held in a 256-entry synchronous memory.
// Each transfer on the req_ channel carries one operation in req_tuser (none, push head,
// push tail, pop head, pop tail, clear) and the word to push in req_tdata.
// Every request gives exactly one transfer on the rsp_ channel: the status in rsp_tuser,
// and the empty flag, entry count, head word and tail word after the operation in rsp_tdata.
// A push into a full queue is rejected with a status, and a pop from an empty queue is
// ignored with a status; neither changes the contents.
// For pushes, clears and queries the result is registered at the accepting edge.
// A pop that leaves entries behind passes through the read state, since the new head or
// tail word comes from the registered memory read port; no request is taken meanwhile.
// The block works on one request at a time, but a new request is taken in the same cycle
// that the previous result is transferred, so a stalled receiver holds the result in the
// output register and blocks only further requests.
// Reset empties the queue at once; no clearing pass runs over the memory.
`default_nettype none

module double_ended_queue_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [deq_pkg::DATA_W-1:0]       req_tdata,   // value
   input  wire logic [deq_pkg::OP_W-1:0]         req_tuser,   // operation
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [deq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // is_empty, entry_count,
                                                              // head_value, tail_value, zeros
   output logic      [deq_pkg::STAT_W-1:0]       rsp_tuser    // status
);
   import deq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [DATA_W-1:0]  head_word_ff, head_word_in;
   logic [DATA_W-1:0]  tail_word_ff, tail_word_in;
   status_type         status_ff, status_in;
   logic               read_head_ff, read_head_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire;
   logic               need_read;
   logic               full;
   logic               empty_now;
   logic               last_one;
   wr_port_type        wr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DATA_W-1:0]  rd_data;

   deq_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign empty_now  = (count_ff == '0);
   assign last_one   = (count_ff == COUNT_W'(1));

   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      head_word_in = head_word_ff;
      tail_word_in = tail_word_ff;
      status_in    = STAT_DONE;
      read_head_in = 1'b0;
      need_read    = 1'b0;
      wr           = '0;
      rd_addr      = head_ff + ADDR_W'(1);
      case (op_type'(req_tuser))
         OP_PUSH_HEAD: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               head_in      = head_ff - ADDR_W'(1);
               wr.en        = 1'b1;
               wr.addr      = head_ff - ADDR_W'(1);
               wr.data      = req_tdata;
               count_in     = count_ff + COUNT_W'(1);
               head_word_in = req_tdata;
               if (empty_now) begin
                  tail_word_in = req_tdata;
               end
            end
         end
         OP_PUSH_TAIL: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               wr.en        = 1'b1;
               wr.addr      = head_ff + count_ff[ADDR_W-1:0];
               wr.data      = req_tdata;
               count_in     = count_ff + COUNT_W'(1);
               tail_word_in = req_tdata;
               if (empty_now) begin
                  head_word_in = req_tdata;
               end
            end
         end
         OP_POP_HEAD: begin
            if (empty_now) begin
               status_in = STAT_EMPTY;
            end else begin
               head_in  = head_ff + ADDR_W'(1);
               count_in = count_ff - COUNT_W'(1);
               if (last_one) begin
                  head_word_in = '0;
                  tail_word_in = '0;
               end else begin
                  need_read    = 1'b1;
                  read_head_in = 1'b1;
                  rd_addr      = head_ff + ADDR_W'(1);
               end
            end
         end
         OP_POP_TAIL: begin
            if (empty_now) begin
               status_in = STAT_EMPTY;
            end else begin
               count_in = count_ff - COUNT_W'(1);
               if (last_one) begin
                  head_word_in = '0;
                  tail_word_in = '0;
               end else begin
                  need_read = 1'b1;
                  rd_addr   = head_ff + ADDR_W'(count_ff - COUNT_W'(2));
               end
            end
         end
         OP_CLEAR: begin
            head_in      = '0;
            count_in     = '0;
            head_word_in = '0;
            tail_word_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && need_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_READ) begin
         rsp_valid_in = 1'b1;
      end else if (req_fire && !need_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff <= count_in;
            head_ff  <= head_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_word_ff <= '0;
         tail_word_ff <= '0;
      end else if (req_fire) begin
         head_word_ff <= head_word_in;
         tail_word_ff <= tail_word_in;
         status_ff    <= status_in;
         read_head_ff <= read_head_in;
      end else if (state_ff == ST_READ) begin
         if (read_head_ff) begin
            head_word_ff <= rd_data;
         end else begin
            tail_word_ff <= rd_data;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_TDATA_W'({tail_word_ff, head_word_ff, count_ff, empty_now});

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("Result register is occupied while a memory read is pending.");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("Entry count exceeds the queue depth.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && empty_now) |-> (head_word_ff == '0 && tail_word_ff == '0))
      else $error("An empty queue reports nonzero head or tail words.");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && need_read) |=> (state_ff == ST_READ && !req_tready))
      else $error("A pop that needs a memory read did not enter the read state.");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (op_type'(req_tuser) == OP_CLEAR)) |=> (count_ff == '0 && head_ff == '0))
      else $error("Clear did not empty the queue.");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   tail;
      logic [DATA_W-1:0]   head;
      logic [COUNT_W-1:0]  count;
      logic                empty;
   } deq_result_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] word;
      bit                typed;
      deq_result_type    result;
   } stim_row_type;

   localparam deq_result_type EMPTY_DONE = '{STAT_DONE, '0, '0, '0, 1'b1};
   localparam deq_result_type EMPTY_POP  = '{STAT_EMPTY, '0, '0, '0, 1'b1};
   localparam deq_result_type PREDICTED  = '{STAT_DONE, '0, '0, '0, 1'b0};

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [DATA_W-1:0]       req_tdata;
   logic [OP_W-1:0]         req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [STAT_W-1:0]       rsp_tuser;

   logic [DATA_W-1:0]       word_store [DEPTH];
   logic [ADDR_W-1:0]       head_slot;
   int                      held;

   deq_result_type          pending_results [$];
   deq_result_type          observed;
   deq_result_type          wanted;
   int                      mismatches;
   int                      stall_left;
   bit                      quiet;
   bit                      hold_rsp;

   stim_row_type directed_rows [22] = '{
      '{OP_NONE,      32'h0000_0000, 1'b1, EMPTY_DONE},
      '{OP_POP_HEAD,  32'h0000_0000, 1'b1, EMPTY_POP},
      '{OP_POP_TAIL,  32'hFFFF_FFFF, 1'b1, EMPTY_POP},
      '{OP_PUSH_HEAD, 32'hFFFF_FFFF, 1'b1,
        '{STAT_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd1, 1'b0}},
      '{OP_PUSH_TAIL, 32'h0000_0000, 1'b1,
        '{STAT_DONE, 32'h0000_0000, 32'hFFFF_FFFF, 9'd2, 1'b0}},
      '{OP_PUSH_HEAD, 32'hA5A5_A5A5, 1'b0, PREDICTED},
      '{OP_PUSH_TAIL, 32'h5A5A_5A5A, 1'b0, PREDICTED},
      '{OP_SPARE_6,   32'hFFFF_FFFF, 1'b0, PREDICTED},
      '{OP_SPARE_7,   32'h1234_5678, 1'b0, PREDICTED},
      '{OP_NONE,      32'hFFFF_FFFF, 1'b0, PREDICTED},
      '{OP_POP_HEAD,  32'h0000_0000, 1'b0, PREDICTED},
      '{OP_POP_TAIL,  32'h0000_0000, 1'b0, PREDICTED},
      '{OP_POP_HEAD,  32'h0000_0000, 1'b0, PREDICTED},
      '{OP_POP_TAIL,  32'h0000_0000, 1'b1, EMPTY_DONE},
      '{OP_POP_TAIL,  32'h0000_0000, 1'b1, EMPTY_POP},
      '{OP_PUSH_TAIL, 32'h1234_5678, 1'b0, PREDICTED},
      '{OP_PUSH_HEAD, 32'h8000_0000, 1'b0, PREDICTED},
      '{OP_CLEAR,     32'h0000_0000, 1'b1, EMPTY_DONE},
      '{OP_CLEAR,     32'hFFFF_FFFF, 1'b1, EMPTY_DONE},
      '{OP_PUSH_HEAD, 32'h0000_0001, 1'b1,
        '{STAT_DONE, 32'h0000_0001, 32'h0000_0001, 9'd1, 1'b0}},
      '{OP_POP_TAIL,  32'h0000_0000, 1'b1, EMPTY_DONE},
      '{OP_PUSH_TAIL, 32'h7FFF_FFFF, 1'b0, PREDICTED}
   };

   double_ended_queue_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end

   function automatic deq_result_type apply_op(input logic [OP_W-1:0] op,
                                               input logic [DATA_W-1:0] word);
      deq_result_type    r;
      logic [ADDR_W-1:0] slot;
      r = PREDICTED;
      case (op)
         OP_PUSH_HEAD: begin
            if (held == DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               head_slot = head_slot - ADDR_W'(1);
               word_store[head_slot] = word;
               held++;
            end
         end
         OP_PUSH_TAIL: begin
            if (held == DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               slot = head_slot + ADDR_W'(held);
               word_store[slot] = word;
               held++;
            end
         end
         OP_POP_HEAD: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               head_slot = head_slot + ADDR_W'(1);
               held--;
            end
         end
         OP_POP_TAIL: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               held--;
            end
         end
         OP_CLEAR: begin
            head_slot = '0;
            held = 0;
         end
         default: begin
         end
      endcase
      r.empty = (held == 0);
      r.count = COUNT_W'(held);
      if (held != 0) begin
         slot = head_slot + ADDR_W'(held - 1);
         r.head = word_store[head_slot];
         r.tail = word_store[slot];
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_W-1:0] random_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return OP_PUSH_HEAD;
      if (r < 50) return OP_PUSH_TAIL;
      if (r < 68) return OP_POP_HEAD;
      if (r < 86) return OP_POP_TAIL;
      if (r < 92) return OP_NONE;
      if (r < 95) return OP_CLEAR;
      if (r < 97) return OP_SPARE_6;
      return OP_SPARE_7;
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word,
                            input bit typed, input deq_result_type typed_result);
      deq_result_type predicted;
      int             gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      predicted = apply_op(op, word);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic report_mismatch(input string what, input deq_result_type want,
                                  input deq_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected status %0d empty %0b count %0d head %h tail %h",
                  what, want.status, want.empty, want.count, want.head, want.tail);
         $display("   got status %0d empty %0b count %0d head %h tail %h",
                  got.status, got.empty, got.count, got.head, got.tail);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed = {rsp_tuser, rsp_tdata[RSP_W-1:0]};
         if (pending_results.size() == 0) begin
            report_mismatch("Unexpected transfer", PREDICTED, observed);
         end else begin
            wanted = pending_results.pop_front();
            if (observed.status !== wanted.status || observed.empty !== wanted.empty ||
                observed.count !== wanted.count || observed.head !== wanted.head ||
                observed.tail !== wanted.tail) begin
               report_mismatch("Result mismatch", wanted, observed);
            end
         end
      end
   end

   initial begin
      rsp_tready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      quiet      = 1'b0;
      hold_rsp   = 1'b0;
      head_slot  = '0;
      held       = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_NONE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
                   directed_rows[i].result);
      end

      repeat (80) send_item(random_op(), random_word(), 1'b0, PREDICTED);

      // Fill to capacity while the receiver holds off, so the input stalls too.
      hold_rsp = 1'b1;
      while (held < DEPTH) begin
         send_item($urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL, random_word(),
                   1'b0, PREDICTED);
      end
      repeat (6) begin
         send_item($urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL, random_word(),
                   1'b0, PREDICTED);
      end
      repeat (20) begin
         case ($urandom_range(0, 3))
            0: send_item(OP_PUSH_HEAD, random_word(), 1'b0, PREDICTED);
            1: send_item(OP_PUSH_TAIL, random_word(), 1'b0, PREDICTED);
            2: send_item(OP_POP_HEAD, random_word(), 1'b0, PREDICTED);
            default: send_item(OP_POP_TAIL, random_word(), 1'b0, PREDICTED);
         endcase
      end

      // Let every outstanding result drain before emptying the queue.
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      while (held > 0) begin
         send_item($urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL, random_word(),
                   1'b0, PREDICTED);
      end
      repeat (3) begin
         send_item($urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL, random_word(),
                   1'b0, PREDICTED);
      end

      repeat (80) send_item(random_op(), random_word(), 1'b0, PREDICTED);
      quiet = 1'b1;
      repeat (60) send_item(random_op(), random_word(), 1'b0, PREDICTED);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
